// ===== design/hfes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hfes_pkg;

  localparam int unsigned NDIV = 32;        // divider stages, two quotient bits each
  localparam int unsigned LAST = NDIV + 3;  // index of the output stage

  localparam logic [2:0] CFG_BIT_SHIFT    = 3'd0;
  localparam logic [2:0] CFG_BIT_COUNT    = 3'd1;
  localparam logic [2:0] CFG_LOGICAL_MIN  = 3'd2;
  localparam logic [2:0] CFG_LOGICAL_MAX  = 3'd3;
  localparam logic [2:0] CFG_SCALE_BITS   = 3'd4;
  localparam logic [2:0] CFG_SCALE_SIGNED = 3'd5;
  localparam logic [2:0] CFG_RANGE_MIN    = 3'd6;
  localparam logic [2:0] CFG_RANGE_MAX    = 3'd7;

  localparam logic REQ_EXTRACT = 1'b0;
  localparam logic REQ_INSERT  = 1'b1;

  localparam logic [31:0] ALL_ONES = 32'hffffffff;

  typedef struct packed {
    logic        req;
    logic        ok;
    logic        neg;    // signed field with negative difference
    logic [31:0] val;
    logic [31:0] wout;
    logic [31:0] src;    // bit rescale source
    logic [31:0] res;    // bit rescale accumulator
    logic [5:0]  t;      // bit rescale remaining target
    logic        done;
    logic [63:0] num;    // dividend, shifted out msb first
    logic [32:0] rem;
    logic [31:0] quo;
  } pipe_t;

endpackage
`default_nettype wire

// ===== design/hfes_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hfes_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] report_word;
  logic [31:0] insert_value;

  modport source (output valid, req_type, report_word, insert_value, input ready);
  modport sink (input valid, req_type, report_word, insert_value, output ready);
endinterface
`default_nettype wire

// ===== design/hfes_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hfes_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] field_value;
  logic        in_range;
  logic [31:0] scaled_bits_value;
  logic [31:0] scaled_range_value;
  logic [31:0] report_word_out;

  modport source (output valid, field_value, in_range, scaled_bits_value,
                  scaled_range_value, report_word_out, input ready);
  modport sink (input valid, field_value, in_range, scaled_bits_value,
                scaled_range_value, report_word_out, output ready);
endinterface
`default_nettype wire

// ===== design/hfes_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hfes_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/hid_field_extract_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  beat contents
// --------  ---  -----------------------------------------------------------
// cfg_ch    in   index, data: one register write, always taken
// in_ch     in   req_type, report_word, insert_value
// out_ch    out  field_value, in_range, scaled_bits_value,
//                scaled_range_value, report_word_out
//
// One beat in per cycle, one result out per cycle, while the output is not stalled.
// The 64/32 divider has 32 stages, two quotient bits each.
// Stages: extract/insert, range check + 32x32 multiply, sign fixup,
// divider (bit replication runs one step per divider stage), output reg.
// Reset (rst_n low, synchronous) empties the pipe and loads register defaults.
// A stalled output freezes the whole pipe; nothing is dropped or repeated.
module hid_field_extract_scale
  import hfes_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  hfes_cfg_if.sink    cfg_ch,
  hfes_in_if.sink     in_ch,
  hfes_out_if.source  out_ch
);

  // configuration registers
  logic [2:0]  bit_shift_r;
  logic [5:0]  bit_count_r;
  logic [31:0] logical_min_r;
  logic [31:0] logical_max_r;
  logic [5:0]  scale_bits_r;
  logic        scale_signed_r;
  logic [31:0] range_min_r;
  logic [31:0] range_max_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_shift_r    <= 3'd0;
      bit_count_r    <= 6'd8;
      logical_min_r  <= 32'd0;
      logical_max_r  <= 32'd255;
      scale_bits_r   <= 6'd8;
      scale_signed_r <= 1'b0;
      range_min_r    <= 32'd0;
      range_max_r    <= 32'd255;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_BIT_SHIFT:    bit_shift_r    <= cfg_ch.data[2:0];
        CFG_BIT_COUNT:    bit_count_r    <= cfg_ch.data[5:0];
        CFG_LOGICAL_MIN:  logical_min_r  <= cfg_ch.data;
        CFG_LOGICAL_MAX:  logical_max_r  <= cfg_ch.data;
        CFG_SCALE_BITS:   scale_bits_r   <= cfg_ch.data[5:0];
        CFG_SCALE_SIGNED: scale_signed_r <= cfg_ch.data[0];
        CFG_RANGE_MIN:    range_min_r    <= cfg_ch.data;
        CFG_RANGE_MAX:    range_max_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // values derived from configuration; the user must keep them static while beats are in flight (not enforced)
  logic [5:0]  fw;       // field width, clamped to 32
  logic [5:0]  sw;       // target width, clamped to 32
  logic [31:0] fmask;
  logic        sgn;      // field is signed
  logic [31:0] divisor;
  logic [31:0] mulv;
  logic [31:0] half;

  assign fw      = (bit_count_r > 6'd32) ? 6'd32 : bit_count_r;
  assign sw      = (scale_bits_r > 6'd32) ? 6'd32 : scale_bits_r;
  assign fmask   = (fw == 6'd0) ? 32'd0 : (ALL_ONES >> (6'd32 - fw));
  assign sgn     = logical_min_r > logical_max_r;
  assign divisor = logical_max_r - logical_min_r + 32'd1;
  assign mulv    = range_max_r - range_min_r + 32'd1;
  assign half    = (logical_max_r + 32'd1) >> 1;

  // pipeline
  pipe_t       pipe_r   [0:LAST];
  pipe_t       pipe_nxt [0:LAST];
  logic [LAST:0] vld_r;
  logic          en;

  assign en          = !vld_r[LAST] || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    pipe_t       p;
    logic [31:0] xv;
    logic [31:0] diff;
    logic [32:0] remw;
    logic [5:0]  shv;
    logic        qb;

    // stage 0: pull the field out of the window, or take the insert value
    p      = '0;
    p.req  = in_ch.req_type;
    p.wout = in_ch.report_word;
    if (in_ch.req_type == REQ_EXTRACT) begin
      xv = (in_ch.report_word >> bit_shift_r) & fmask;
      if (sgn && ((xv & ~(fmask >> 1)) != 32'd0)) begin
        xv = xv | ~fmask;
      end
    end else begin
      xv = in_ch.insert_value;
    end
    p.val       = xv;
    pipe_nxt[0] = p;

    // stage 1: range check, window update, rescale source, multiply
    p = pipe_r[0];
    if (sgn) begin
      p.ok = ($signed(p.val) >= $signed(logical_min_r)) &&
             ($signed(p.val) <= $signed(logical_max_r));
    end else begin
      p.ok = (p.val >= logical_min_r) && (p.val <= logical_max_r);
    end
    if (p.req == REQ_INSERT) begin
      p.wout = p.wout & ~(fmask << bit_shift_r);
      if (p.ok) begin
        p.wout = p.wout | ((p.val & fmask) << bit_shift_r);
      end
    end
    diff = p.val - logical_min_r;
    if (sgn != scale_signed_r) begin
      p.src = scale_signed_r ? ((p.val - half) & fmask) : diff;
    end else begin
      p.src = p.val & fmask;
    end
    p.neg       = sgn && diff[31];
    p.num       = {32'd0, diff} * {32'd0, mulv};
    pipe_nxt[1] = p;

    // stage 2: sign-extended difference times multiplier, mod 2^64
    p = pipe_r[1];
    if (p.neg) begin
      p.num = p.num - {mulv, 32'd0};
    end
    p.rem       = '0;
    p.quo       = '0;
    p.res       = '0;
    p.t         = sw;
    p.done      = 1'b0;
    pipe_nxt[2] = p;

    // divider stages; one bit-replication step rides along in each
    for (int k = 3; k < LAST; k++) begin
      p = pipe_r[k-1];
      for (int b = 0; b < 2; b++) begin
        remw  = {p.rem[31:0], p.num[63]};
        p.num = p.num << 1;
        qb    = remw >= {1'b0, divisor};
        if (qb) begin
          remw = remw - {1'b0, divisor};
        end
        p.rem = remw;
        p.quo = {p.quo[30:0], qb};
      end
      shv = fw - p.t;
      if (!p.done) begin
        if (p.t > fw) begin
          p.t   = p.t - fw;
          p.res = p.res | (p.src << p.t);
        end else begin
          p.res  = p.res | (p.src >> shv);
          p.done = 1'b1;
        end
      end
      pipe_nxt[k] = p;
    end

    // output stage: special cases and offset
    p     = pipe_r[LAST-1];
    p.quo = (divisor == 32'd0) ? range_min_r : (p.quo + range_min_r);
    if (sw == fw) begin
      p.res = p.src;
    end else if (fw == 6'd0) begin
      p.res = 32'd0;
    end
    pipe_nxt[LAST] = p;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_ch.valid};
    end
  end

  assign out_ch.valid              = vld_r[LAST];
  assign out_ch.field_value        = pipe_r[LAST].val;
  assign out_ch.in_range           = pipe_r[LAST].ok;
  assign out_ch.scaled_bits_value  = pipe_r[LAST].res;
  assign out_ch.scaled_range_value = pipe_r[LAST].quo;
  assign out_ch.report_word_out    = pipe_r[LAST].wout;

`ifndef SYNTHESIS
  // replication loop must have finished by the end of the divider
  a_bits_done: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST-1] |-> (pipe_r[LAST-1].done || (sw == fw) || (fw == 6'd0)))
    else $error("bit rescale not finished at divider exit");

  // remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAST-1] && (divisor != 32'd0)) |-> (pipe_r[LAST-1].rem < {1'b0, divisor}))
    else $error("divider remainder out of range");

  // a stall freezes every stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipe moved during stall");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipe not empty after reset");
`endif

endmodule
`default_nettype wire

// ===== dv/hfes_checker.sv =====
`timescale 1ns / 1ps
module hfes_checker
  import hfes_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  hfes_cfg_if.sink  cfg_ch,
  hfes_in_if.sink   in_ch,
  hfes_out_if.sink  out_ch,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic [31:0] field_value;
    logic        in_range;
    logic [31:0] scaled_bits_value;
    logic [31:0] scaled_range_value;
    logic [31:0] report_word_out;
  } field_result_t;

  logic [2:0]  r_shift;
  logic [5:0]  r_count;
  logic [31:0] r_lmin, r_lmax;
  logic [5:0]  r_sbits;
  logic        r_ssigned;
  logic [31:0] r_rmin, r_rmax;

  field_result_t result_q[$];

  assign pending = result_q.size();

  function automatic logic [31:0] fmask();
    int unsigned w;
    w = (r_count > 32) ? 32 : r_count;
    if (w == 0) return 32'd0;
    if (w >= 32) return ALL_ONES;
    return (32'd1 << w) - 32'd1;
  endfunction

  function automatic logic is_sgn();
    return r_lmin > r_lmax;
  endfunction

  function automatic logic range_ok(logic [31:0] v);
    if (is_sgn())
      return $signed(v) >= $signed(r_lmin) && $signed(v) <= $signed(r_lmax);
    return v >= r_lmin && v <= r_lmax;
  endfunction

  function automatic logic [31:0] bit_rescale(logic [31:0] v);
    logic [31:0] src, res, lm1;
    int unsigned w, s, sh;
    w = (r_count > 32) ? 32 : r_count;
    s = (r_sbits > 32) ? 32 : r_sbits;
    res = 0;
    lm1 = r_lmax + 32'd1;
    if (is_sgn() != r_ssigned) begin
      if (r_ssigned) src = (v - (lm1 >> 1)) & fmask();
      else src = v - r_lmin;
    end else begin
      src = v & fmask();
    end
    if (s == w) return src;
    if (w == 0) return 32'd0;
    forever begin
      if (s > w) begin
        sh = s - w;
        res |= src << sh;
        s = sh;
      end else begin
        sh = w - s;
        if (sh < 32) res |= src >> sh;
        break;
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] range_rescale(logic [31:0] v);
    logic [31:0] diff, mul, dvs;
    logic [63:0] d, p;
    diff = v - r_lmin;
    mul = r_rmax - r_rmin + 32'd1;
    dvs = r_lmax - r_lmin + 32'd1;
    d = {32'd0, diff};
    if (is_sgn() && diff[31]) d[63:32] = ALL_ONES;
    if (dvs == 0) return r_rmin;
    p = d * {32'd0, mul};
    p = p / {32'd0, dvs} + {32'd0, r_rmin};
    return p[31:0];
  endfunction

  function automatic field_result_t predict_field(logic req, logic [31:0] word,
                                                  logic [31:0] ins);
    field_result_t r;
    logic [31:0] m, v;
    m = fmask();
    r.report_word_out = word;
    if (req == REQ_EXTRACT) begin
      v = (word >> r_shift) & m;
      if (is_sgn() && (v & ~(m >> 1)) != 0) v |= ~m;
      r.in_range = range_ok(v);
    end else begin
      v = ins;
      r.in_range = range_ok(v);
      r.report_word_out = word & ~(m << r_shift);
      if (r.in_range) r.report_word_out |= (v & m) << r_shift;
    end
    r.field_value = v;
    r.scaled_bits_value = bit_rescale(v);
    r.scaled_range_value = range_rescale(v);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    field_result_t e;
    if (!rst_n) begin
      r_shift <= 0; r_count <= 8; r_lmin <= 0; r_lmax <= 255;
      r_sbits <= 8; r_ssigned <= 0; r_rmin <= 0; r_rmax <= 255;
      fail_count = 0;
      result_q.delete();
    end else begin
      // config and input never overlap, so predicting with current regs is safe
      if (in_ch.valid && in_ch.ready)
        result_q.push_back(predict_field(in_ch.req_type, in_ch.report_word,
                                         in_ch.insert_value));
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected beat", out_ch.field_value, 32'd0);
        end else begin
          e = result_q.pop_front();
          if (out_ch.field_value !== e.field_value)
            report_mismatch("field_value", out_ch.field_value, e.field_value);
          if (out_ch.in_range !== e.in_range)
            report_mismatch("in_range", {31'd0, out_ch.in_range}, {31'd0, e.in_range});
          if (out_ch.scaled_bits_value !== e.scaled_bits_value)
            report_mismatch("scaled_bits_value", out_ch.scaled_bits_value,
                            e.scaled_bits_value);
          if (out_ch.scaled_range_value !== e.scaled_range_value)
            report_mismatch("scaled_range_value", out_ch.scaled_range_value,
                            e.scaled_range_value);
          if (out_ch.report_word_out !== e.report_word_out)
            report_mismatch("report_word_out", out_ch.report_word_out,
                            e.report_word_out);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_BIT_SHIFT:    r_shift <= cfg_ch.data[2:0];
          CFG_BIT_COUNT:    r_count <= cfg_ch.data[5:0];
          CFG_LOGICAL_MIN:  r_lmin <= cfg_ch.data;
          CFG_LOGICAL_MAX:  r_lmax <= cfg_ch.data;
          CFG_SCALE_BITS:   r_sbits <= cfg_ch.data[5:0];
          CFG_SCALE_SIGNED: r_ssigned <= cfg_ch.data[0];
          CFG_RANGE_MIN:    r_rmin <= cfg_ch.data;
          CFG_RANGE_MAX:    r_rmax <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench
  import hfes_pkg::*;
();

  localparam int PIPE_LAT  = 36;
  localparam int STALL_MAX = 200000;  // cycles with no beat before giving up

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  bit   in_active = 0;   // receiver stalls only while stimulus runs
  bit   hold_sink = 0;   // long receiver hold-off request
  int   idle_cycles = 0;

  always #2 clk = ~clk;

  hfes_cfg_if cfg_ch ();
  hfes_in_if  in_ch ();
  hfes_out_if out_ch ();

  hid_field_extract_scale i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hfes_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Gap length: mostly 0..3, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Receiver: random ready, with a long hold-off when asked.
  initial begin
    int g;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
      end else if (in_active && $urandom_range(0, 3) == 0) begin
        g = gap_len();
        out_ch.ready <= (g == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || hold_sink)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("[hid_field_extract_scale] ERROR");
      $finish;
    end
  end

  // One write, then valid is dropped before the next so back-to-back writes never collide.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drain: wait for all results, then let the pipe settle.
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic send_beat(logic req, logic [31:0] word, logic [31:0] ins);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= req;
    in_ch.report_word  <= word;
    in_ch.insert_value <= ins;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_setting(logic [2:0] sh, logic [5:0] cnt, logic [31:0] lmin,
                              logic [31:0] lmax, logic [5:0] sb, logic ss,
                              logic [31:0] rmin, logic [31:0] rmax);
    write_reg(CFG_BIT_SHIFT, {29'd0, sh});
    write_reg(CFG_BIT_COUNT, {26'd0, cnt});
    write_reg(CFG_LOGICAL_MIN, lmin);
    write_reg(CFG_LOGICAL_MAX, lmax);
    write_reg(CFG_SCALE_BITS, {26'd0, sb});
    write_reg(CFG_SCALE_SIGNED, {31'd0, ss});
    write_reg(CFG_RANGE_MIN, rmin);
    write_reg(CFG_RANGE_MAX, rmax);
  endtask

  // Values near the logical bounds hit in/out of range often.
  function automatic logic [31:0] pick_value(logic [31:0] lmin, logic [31:0] lmax);
    case ($urandom_range(0, 5))
      0: return lmin + $urandom_range(0, 2) - 1;
      1: return lmax + $urandom_range(0, 2) - 1;
      2: return $urandom_range(0, 255);
      3: return ALL_ONES - $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_setting(output logic [31:0] lmin, output logic [31:0] lmax);
    logic [5:0] cnt;
    logic [31:0] half;
    cnt = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
          6'($urandom_range(1, 16));
    half = (cnt >= 32 || cnt == 0) ? 32'h7fffffff : (32'd1 << (cnt - 1)) - 1;
    case ($urandom_range(0, 3))
      0: begin lmin = 0; lmax = {half[30:0], 1'b1}; end     // full unsigned
      1: begin lmin = -half - 1; lmax = half; end          // full signed
      2: begin lmin = -($urandom_range(1, 100)); lmax = $urandom_range(0, 100); end
      default: begin lmin = $urandom; lmax = $urandom; end
    endcase
    load_setting(3'($urandom_range(0, 7)), cnt, lmin, lmax,
                 ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
                 6'($urandom_range(1, 32)),
                 1'($urandom_range(0, 1)), $urandom, $urandom);
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CFG_RANGE_MIN, $urandom_range(0, 50));
      write_reg(CFG_RANGE_MAX, $urandom_range(100, 4000));
    end
  endtask

  initial begin
    logic [31:0] lmin, lmax;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_BIT_SHIFT;
    cfg_ch.data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.req_type = REQ_EXTRACT;
    in_ch.report_word = '0;
    in_ch.insert_value = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    in_active = 1;

    // Directed: reset defaults, window extremes, both request kinds.
    send_beat(REQ_EXTRACT, 32'h0, 32'h0);
    send_beat(REQ_EXTRACT, ALL_ONES, 32'h0);
    send_beat(REQ_INSERT, ALL_ONES, 32'h0000_00ff);
    send_beat(REQ_INSERT, 32'h0, 32'h0000_0100);  // out of range, field only cleared
    send_beat(REQ_INSERT, 32'ha5a5_a5a5, ALL_ONES);
    end_burst();
    wait_drained();

    // Signed field (min > max unsigned), shift 7, recentred to unsigned scale.
    load_setting(3'd7, 6'd12, 32'hffff_f800, 32'h0000_07ff, 6'd16, 1'b0,
                 32'd0, 32'd65535);
    send_beat(REQ_EXTRACT, 32'h0004_0000, 32'h0);   // most negative
    send_beat(REQ_EXTRACT, 32'h0003_ff80, 32'h0);   // most positive
    send_beat(REQ_EXTRACT, ALL_ONES, 32'h0);
    send_beat(REQ_INSERT, 32'h5555_5555, 32'hffff_f800);
    send_beat(REQ_INSERT, 32'h5555_5555, 32'h0000_0800); // just above max
    end_burst();
    wait_drained();

    // Full 32-bit field, zero divisor (min 0, max all ones), 32-bit scale.
    load_setting(3'd0, 6'd32, 32'd0, ALL_ONES, 6'd32, 1'b1, ALL_ONES, 32'd0);
    send_beat(REQ_EXTRACT, ALL_ONES, 32'h0);
    send_beat(REQ_EXTRACT, 32'h8000_0000, 32'h0);
    send_beat(REQ_INSERT, 32'h1234_5678, 32'h8765_4321);
    end_burst();
    wait_drained();

    // Zero bit count and bit count / scale bits above 32.
    load_setting(3'd3, 6'd0, 32'd0, 32'd0, 6'd0, 1'b0, 32'd10, 32'd20);
    send_beat(REQ_EXTRACT, ALL_ONES, 32'h0);
    send_beat(REQ_INSERT, ALL_ONES, 32'h0);
    end_burst();
    wait_drained();
    load_setting(3'd5, 6'd63, 32'h8000_0000, 32'h7fff_ffff, 6'd63, 1'b1,
                 32'd0, ALL_ONES);
    send_beat(REQ_EXTRACT, ALL_ONES, 32'h0);
    send_beat(REQ_INSERT, 32'h0, 32'h8000_0000);
    end_burst();
    wait_drained();

    // One-bit field scaled up to many bits.
    load_setting(3'd1, 6'd1, 32'd0, 32'd1, 6'd31, 1'b0, 32'd100, 32'd50);
    send_beat(REQ_EXTRACT, 32'h2, 32'h0);
    send_beat(REQ_EXTRACT, 32'h0, 32'h0);
    send_beat(REQ_INSERT, 32'h0, 32'h1);
    end_burst();
    wait_drained();

    // Receiver holds off long while the sender keeps offering.
    fork
      begin
        hold_sink = 1;
        repeat (300) @(negedge clk);
        hold_sink = 0;
      end
      for (int k = 0; k < 80; k++)
        send_beat(1'($urandom_range(0, 1)), $urandom, $urandom);
    join
    end_burst();
    wait_drained();

    // Random phases; each starts from idle with a fresh setting.
    for (int ph = 0; ph < 30; ph++) begin
      random_setting(lmin, lmax);
      for (int k = 0; k < 38; k++)
        send_beat(1'($urandom_range(0, 1)), $urandom,
                  pick_value(lmin, lmax));
      // sender pause until every result is back (also needed before config)
      end_burst();
      wait_drained();
    end

    in_active = 0;
    if (fail_count == 0)
      $display("[hid_field_extract_scale] OK");
    else
      $display("[hid_field_extract_scale] ERROR");
    $finish;
  end

endmodule
